### sv/tlv_pkg.sv
package tlv_pkg;

  localparam int MaxFields = 16;
  localparam int MaxPath   = 64;
  localparam int QDepth    = 4;

  typedef enum logic [2:0] {
    K_EVENT  = 3'd0,
    K_FIELD  = 3'd1,
    K_SBYTE  = 3'd2,
    K_SEND   = 3'd3,
    K_APPEND = 3'd4,
    K_OK     = 3'd5,
    K_ERR    = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  item_id;
    logic [63:0] value;
    logic [4:0]  field_index;
    logic [5:0]  byte_index;
    logic        last_result;
  } out_item_t;

  // one decoded step: up to four results, valid count
  typedef struct packed {
    logic [2:0]      count;
    out_item_t [3:0] res;
  } step_t;

endpackage

### sv/tlv_event_record_decoder_unit.sv
// Byte-serial TLV event decoder. One byte is accepted per cycle; the front
// parser classifies each byte and posts its results (up to four) into a
// four-entry queue. The back end drains one result per cycle as out_ready
// allows, so bytes that cause several results stall the input only once
// the queue fills. last_byte resets the parser for the next buffer.
module tlv_event_record_decoder_unit import tlv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      in_valid,
  output logic      in_ready,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready
);

  step_t step;
  logic  step_valid, step_ready;

  tlv_front u_front (
    .clk, .rst, .in_item, .in_valid, .in_ready,
    .step, .step_valid, .step_ready
  );

  tlv_back u_back (
    .clk, .rst, .step, .step_valid, .step_ready,
    .out_item, .out_valid, .out_ready
  );

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.kind <= K_ERR) else $error("bad kind");
  a_step_nonempty: assert property (@(posedge clk) disable iff (rst)
    step_valid |-> step.count != 3'd0) else $error("empty step");
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind == K_OK || out_item.kind == K_ERR) |-> out_item.last_result)
    else $error("ok/error not last");

endmodule

### sv/tlv_front.sv
module tlv_front import tlv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t in_item,
  input  logic     in_valid,
  output logic     in_ready,
  output step_t    step,
  output logic     step_valid,
  input  logic     step_ready
);

  typedef enum logic [3:0] {
    PH_EV_HDR, PH_OUT_HDR, PH_OUT_VAL, PH_OUT_SKIP, PH_OUT_TRAIL,
    PH_IN_HDR, PH_IN_VAL, PH_IN_STR, PH_IN_SKIP, PH_IN_TRAIL, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  header_bytes, header_bytes_next;
  logic [32:0] outer_offset, outer_offset_next;
  logic [32:0] event_end, event_end_next;
  logic [31:0] record_tag, record_tag_next;
  logic [31:0] record_length, record_length_next;
  logic [31:0] inner_tag, inner_tag_next;
  logic [31:0] inner_length, inner_length_next;
  logic [63:0] asm_sh, asm_sh_next;
  logic [4:0]  fields_stored, fields_stored_next;
  logic [5:0]  string_count, string_count_next;
  step_t       st;

  logic        fire;
  logic [63:0] tb;
  logic [31:0] flen;
  logic [31:0] olen;
  logic [63:0] v;

  assign in_ready = !step_valid || step_ready;
  assign fire     = in_valid && in_ready;

  function automatic step_t push(step_t s, kind_t k, logic [2:0] id, logic [63:0] val,
                                 logic [4:0] fi, logic [5:0] bi);
    step_t r;
    r = s;
    if (s.count < 3'd4) begin
      r.res[s.count[1:0]] = '{kind: k, item_id: id, value: val, field_index: fi,
                              byte_index: bi, last_result: 1'b0};
      r.count = s.count + 3'd1;
    end
    return r;
  endfunction

  always_comb begin
    phase_next         = phase;
    header_bytes_next  = header_bytes;
    outer_offset_next  = outer_offset;
    event_end_next     = event_end;
    record_tag_next    = record_tag;
    record_length_next = record_length;
    inner_tag_next     = inner_tag;
    inner_length_next  = inner_length;
    asm_sh_next        = asm_sh;
    fields_stored_next = fields_stored;
    string_count_next  = string_count;
    st                 = '0;
    tb   = asm_sh | ({56'd0, in_item.data_byte} << {header_bytes, 3'b000});
    flen = tb[63:32];
    olen = tb[63:32];
    v    = '0;
    if (phase != PH_DONE) begin
      outer_offset_next = outer_offset + 33'd1;
      unique case (phase)
        PH_EV_HDR: begin
          asm_sh_next = tb;
          if (header_bytes == 3'd3 && tb[31:0] != 32'd1) begin
            st = push(st, K_ERR, 3'd0, '0, '0, '0);
            phase_next = PH_DONE;
          end else if (header_bytes == 3'd7) begin
            event_end_next = 33'd8 + {1'b0, tb[63:32]};
            header_bytes_next = '0;
            asm_sh_next = '0;
            phase_next = PH_OUT_HDR;
          end else begin
            header_bytes_next = header_bytes + 3'd1;
          end
        end
        PH_OUT_HDR: begin
          if (header_bytes == 3'd0 && (event_end - outer_offset) < 33'd8) begin
            phase_next = PH_OUT_TRAIL;
          end else if (header_bytes != 3'd7) begin
            asm_sh_next = tb;
            header_bytes_next = header_bytes + 3'd1;
          end else begin
            record_tag_next = tb[31:0];
            header_bytes_next = '0;
            asm_sh_next = '0;
            if ({1'b0, outer_offset_next} + {2'b00, olen} > {1'b0, event_end}) begin
              st = push(st, K_ERR, 3'd0, '0, '0, '0);
              phase_next = PH_DONE;
            end else begin
              record_length_next = olen;
              if (olen == 32'd0) phase_next = PH_OUT_HDR;
              else if ((tb[31:0] >= 32'd2 && tb[31:0] <= 32'd6 && olen == 32'd4) ||
                       (tb[31:0] == 32'd7 && olen == 32'd8))
                phase_next = PH_OUT_VAL;
              else if (tb[31:0] == 32'd9 && 32'(fields_stored) < 32'(MaxFields))
                phase_next = PH_IN_HDR;
              else phase_next = PH_OUT_SKIP;
            end
          end
        end
        PH_OUT_VAL: begin
          asm_sh_next = tb;
          header_bytes_next = header_bytes + 3'd1;
          record_length_next = record_length - 32'd1;
          if (record_length_next == 32'd0) begin
            v = tb;
            if (record_tag == 32'd2 || record_tag == 32'd3) v = {48'd0, tb[15:0]};
            else if (record_tag == 32'd4 || record_tag == 32'd5) v = {56'd0, tb[7:0]};
            else if (record_tag == 32'd6) v = {32'd0, tb[31:0]};
            st = push(st, K_EVENT, 3'(record_tag - 32'd2), v, '0, '0);
            header_bytes_next = '0;
            asm_sh_next = '0;
            phase_next = PH_OUT_HDR;
          end
        end
        PH_OUT_SKIP: begin
          record_length_next = record_length - 32'd1;
          if (record_length_next == 32'd0) phase_next = PH_OUT_HDR;
        end
        PH_OUT_TRAIL: ;
        PH_IN_HDR, PH_IN_VAL, PH_IN_STR, PH_IN_SKIP, PH_IN_TRAIL: begin
          unique case (phase)
            PH_IN_HDR: begin
              if (header_bytes == 3'd0 && record_length < 32'd8) begin
                phase_next = PH_IN_TRAIL;
              end else if (header_bytes != 3'd7) begin
                asm_sh_next = tb;
                header_bytes_next = header_bytes + 3'd1;
              end else begin
                inner_tag_next = tb[31:0];
                header_bytes_next = '0;
                asm_sh_next = '0;
                if (flen > record_length - 32'd1) begin
                  phase_next = PH_IN_TRAIL;
                end else begin
                  inner_length_next = flen;
                  if (tb[31:0] == 32'd6) begin
                    string_count_next = '0;
                    if (flen == 32'd0) st = push(st, K_SEND, 3'd0, '0, fields_stored, '0);
                    else phase_next = PH_IN_STR;
                  end else if ((tb[31:0] >= 32'd1 && tb[31:0] <= 32'd4 && flen == 32'd4) ||
                               (tb[31:0] == 32'd5 && flen == 32'd8)) begin
                    phase_next = PH_IN_VAL;
                  end else if (flen != 32'd0) begin
                    phase_next = PH_IN_SKIP;
                  end
                end
              end
            end
            PH_IN_VAL: begin
              asm_sh_next = tb;
              header_bytes_next = header_bytes + 3'd1;
              inner_length_next = inner_length - 32'd1;
              if (inner_length_next == 32'd0) begin
                v = tb;
                if (inner_tag == 32'd2 || inner_tag == 32'd3) v = {56'd0, tb[7:0]};
                else if (inner_tag != 32'd5) v = {32'd0, tb[31:0]};
                st = push(st, K_FIELD, 3'(inner_tag - 32'd1), v, fields_stored, '0);
                header_bytes_next = '0;
                asm_sh_next = '0;
                phase_next = PH_IN_HDR;
              end
            end
            PH_IN_STR: begin
              if (32'(string_count) < 32'(MaxPath - 1)) begin
                st = push(st, K_SBYTE, 3'd0, {56'd0, in_item.data_byte}, fields_stored,
                          string_count);
                string_count_next = string_count + 6'd1;
              end
              inner_length_next = inner_length - 32'd1;
              if (inner_length_next == 32'd0) begin
                st = push(st, K_SEND, 3'd0, {58'd0, string_count_next}, fields_stored,
                          string_count_next);
                phase_next = PH_IN_HDR;
              end
            end
            PH_IN_SKIP: begin
              inner_length_next = inner_length - 32'd1;
              if (inner_length_next == 32'd0) phase_next = PH_IN_HDR;
            end
            default: ;
          endcase
          record_length_next = record_length - 32'd1;
          if (record_length_next == 32'd0) begin
            st = push(st, K_APPEND, 3'd0, '0, fields_stored, '0);
            fields_stored_next = fields_stored + 5'd1;
            header_bytes_next = '0;
            asm_sh_next = '0;
            phase_next = PH_OUT_HDR;
          end
        end
        default: ;
      endcase
      if (phase_next != PH_DONE && phase_next != PH_EV_HDR &&
          outer_offset_next == event_end_next) begin
        st = push(st, K_OK, 3'd0, {31'd0, event_end_next}, '0, '0);
        phase_next = PH_DONE;
      end
      if (in_item.last_byte && phase_next != PH_DONE)
        st = push(st, K_ERR, 3'd0, '0, '0, '0);
    end
    if (st.count != 3'd0) st.res[2'(st.count - 3'd1)].last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && in_item.last_byte)) begin
      phase         <= PH_EV_HDR;
      header_bytes  <= '0;
      outer_offset  <= '0;
      event_end     <= '0;
      record_tag    <= '0;
      record_length <= '0;
      inner_tag     <= '0;
      inner_length  <= '0;
      asm_sh        <= '0;
      fields_stored <= '0;
      string_count  <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      header_bytes  <= header_bytes_next;
      outer_offset  <= outer_offset_next;
      event_end     <= event_end_next;
      record_tag    <= record_tag_next;
      record_length <= record_length_next;
      inner_tag     <= inner_tag_next;
      inner_length  <= inner_length_next;
      asm_sh        <= asm_sh_next;
      fields_stored <= fields_stored_next;
      string_count  <= string_count_next;
    end
    if (rst) begin
      step_valid <= 1'b0;
    end else if (fire) begin
      step_valid <= st.count != 3'd0;
    end else if (step_ready) begin
      step_valid <= 1'b0;
    end
    if (fire) step <= st;
  end

endmodule

### sv/tlv_back.sv
module tlv_back import tlv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  step_t     step,
  input  logic      step_valid,
  output logic      step_ready,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready
);

  localparam int PtrW = $clog2(QDepth);

  step_t            q [QDepth];
  logic [PtrW-1:0]  wp, rp;
  logic [PtrW:0]    cnt;
  logic [1:0]       sub;
  logic             push_q, pop_q, last_sub;
  step_t            head;

  assign head       = q[rp];
  assign step_ready = cnt != (PtrW+1)'(QDepth);
  assign push_q     = step_valid && step_ready;
  assign out_valid  = cnt != '0;
  assign out_item   = head.res[sub];
  assign last_sub   = ({1'b0, sub} + 3'd1) == head.count;
  assign pop_q      = out_valid && out_ready && last_sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
      sub <= '0;
    end else begin
      if (push_q) wp <= wp + 1'b1;
      if (pop_q) rp <= rp + 1'b1;
      cnt <= cnt + (PtrW+1)'(push_q) - (PtrW+1)'(pop_q);
      if (out_valid && out_ready) sub <= last_sub ? 2'd0 : sub + 2'd1;
    end
    if (push_q) q[wp] <= step;
  end

endmodule
